// ===== src/hrfg_pkg.sv =====
// Package for the history ring with flush gate.
// Item types, sample pair type and reset constants; no dependencies.
package hrfg_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam logic [31:0] FLUSH_INTERVAL_RESET = 32'(10 * 60 * 1000);

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  session_in;
    logic [7:0]  weekly_in;
    logic [5:0]  index;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        read_valid;
    logic [7:0]  session_out;
    logic [7:0]  weekly_out;
    logic [6:0]  sample_count;
    logic        flush_due;
  } out_item_t;

  typedef struct packed {
    logic [7:0] session;
    logic [7:0] weekly;
  } sample_pair_t;

endpackage

// ===== src/hrfg_ram.sv =====
// Sample pair memory: one port, synchronous write, registered read.
// Uses hrfg_pkg for the pair type.
module hrfg_ram #(
  parameter int Depth = hrfg_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic                      rd_en,
  input  logic [$clog2(Depth)-1:0]  addr,
  input  hrfg_pkg::sample_pair_t    wr_data,
  output hrfg_pkg::sample_pair_t    rd_data
);
  import hrfg_pkg::*;

  sample_pair_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== src/hrfg_flush_gate.sv =====
// Flush gate: interval register, first-flush flag and last flush time.
// Uses hrfg_pkg for the interval reset value.
module hrfg_flush_gate (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        push,
  input  logic [31:0] now_ms,
  output logic        due
);
  import hrfg_pkg::*;

  logic [31:0] flush_interval;
  logic [31:0] last_flush_time;
  logic        flushed_once;
  logic [31:0] elapsed;

  // Wrap-around time difference, modulo two to the 32
  assign elapsed = now_ms - last_flush_time;
  assign due     = !flushed_once || (elapsed >= flush_interval);

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_interval  <= FLUSH_INTERVAL_RESET;
      last_flush_time <= '0;
      flushed_once    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        flush_interval <= cfg_data;
      end
      if (push && due) begin
        flushed_once    <= 1'b1;
        last_flush_time <= now_ms;
      end
    end
  end

endmodule

// ===== src/hrfg_ring_ctrl.sv =====
// Ring control: oldest slot, count, memory addressing and result register.
// Uses hrfg_pkg for item and pair types.
module hrfg_ring_ctrl #(
  parameter int Depth = hrfg_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  hrfg_pkg::in_item_t        item,
  input  logic                      due,
  output logic                      push,
  output logic                      mem_wr_en,
  output logic                      mem_rd_en,
  output logic [$clog2(Depth)-1:0]  mem_addr,
  output hrfg_pkg::sample_pair_t    mem_wr_data,
  input  hrfg_pkg::sample_pair_t    mem_rd_data,
  output logic                      done,
  output hrfg_pkg::out_item_t       result
);
  import hrfg_pkg::*;

  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int ExtW  = (CntW > 7) ? CntW : 7;
  localparam int SumW  = ExtW + 1;

  logic [AddrW-1:0] oldest;
  logic [CntW-1:0]  count;
  logic             rd_pending;
  logic             rd_hit;

  logic             accept;
  logic             full;
  logic             hit;
  logic [ExtW-1:0]  count_ext;
  logic [ExtW-1:0]  offset;
  logic [SumW-1:0]  sum;
  logic [SumW-1:0]  slot_wide;
  logic [AddrW-1:0] oldest_next;
  logic [CntW-1:0]  count_next;
  logic [ExtW-1:0]  count_next_ext;

  assign busy   = rd_pending;
  assign accept = start && !busy;
  assign push   = accept && (item.mode == MODE_PUSH);
  assign full   = (count == CntW'(Depth));

  assign count_ext = ExtW'(count);
  assign hit       = ExtW'(item.index) < count_ext;

  // Logical offset from the oldest slot; full ring writes over the oldest
  always_comb begin
    if (item.mode == MODE_PUSH) begin
      offset = full ? '0 : count_ext;
    end else begin
      offset = ExtW'(item.index);
    end
    sum = SumW'(oldest) + SumW'(offset);
    if (sum >= SumW'(Depth)) begin
      slot_wide = sum - SumW'(Depth);
    end else begin
      slot_wide = sum;
    end
  end

  always_comb begin
    oldest_next = oldest;
    count_next  = count;
    if (full) begin
      oldest_next = (oldest == AddrW'(Depth - 1)) ? '0 : oldest + 1'b1;
    end else begin
      count_next = count + 1'b1;
    end
  end

  assign count_next_ext = ExtW'(count_next);

  assign mem_addr    = slot_wide[AddrW-1:0];
  assign mem_wr_en   = push;
  assign mem_rd_en   = accept && (item.mode == MODE_READ);
  assign mem_wr_data = '{session: item.session_in, weekly: item.weekly_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      count      <= '0;
      rd_pending <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      rd_pending <= 1'b0;
      if (push) begin
        oldest              <= oldest_next;
        count               <= count_next;
        done                <= 1'b1;
        result.read_valid   <= 1'b0;
        result.session_out  <= '0;
        result.weekly_out   <= '0;
        result.sample_count <= count_next_ext[6:0];
        result.flush_due    <= due;
      end else if (mem_rd_en) begin
        // Hold the hit flag until the memory data returns
        rd_pending <= 1'b1;
        rd_hit     <= hit;
      end
      if (rd_pending) begin
        done                <= 1'b1;
        result.read_valid   <= rd_hit;
        result.session_out  <= rd_hit ? mem_rd_data.session : '0;
        result.weekly_out   <= rd_hit ? mem_rd_data.weekly : '0;
        result.sample_count <= count_ext[6:0];
        result.flush_due    <= 1'b0;
      end
    end
  end

endmodule

// ===== src/history_ring_with_flush_gate_unit.sv =====
// History ring with flush gate, top level.
// Instantiates hrfg_ring_ctrl, hrfg_ram and hrfg_flush_gate; uses hrfg_pkg.
//
// A push's result appears with done in the cycle after start is taken; a new
// item may follow at once. A read's result is registered from the sample
// memory's registered read data; busy is high for the cycle after the read is
// taken. Every item gives exactly one result, shown for one cycle only; the
// receiver must take it then, as it cannot stall the block. The flush
// interval is written through cfg_valid/cfg_data, always ready; the user must
// write it only while idle, which the block does not enforce.
module history_ring_with_flush_gate_unit #(
  parameter int Depth = hrfg_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hrfg_pkg::in_item_t  item,
  output logic                done,
  output hrfg_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import hrfg_pkg::*;

  logic                     push;
  logic                     due;
  logic                     mem_wr_en;
  logic                     mem_rd_en;
  logic [$clog2(Depth)-1:0] mem_addr;
  sample_pair_t             mem_wr_data;
  sample_pair_t             mem_rd_data;

  assign cfg_ready = 1'b1;

  hrfg_ring_ctrl #(.Depth(Depth)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .due         (due),
    .push        (push),
    .mem_wr_en   (mem_wr_en),
    .mem_rd_en   (mem_rd_en),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data),
    .done        (done),
    .result      (result)
  );

  hrfg_ram #(.Depth(Depth)) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (mem_rd_en),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  hrfg_flush_gate u_gate (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .now_ms    (item.now_ms),
    .due       (due)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for history_ring_with_flush_gate_unit.
// Drives pushes, reads and flush-interval writes, predicts every result in a
// small tracker class and checks it; depends on hrfg_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrfg_pkg::*;

  class ring_tracker;
    logic [7:0]  session_mem [DEPTH_DEFAULT];
    logic [7:0]  weekly_mem [DEPTH_DEFAULT];
    logic [5:0]  oldest = '0;
    logic [6:0]  held = '0;
    logic        dirty = 1'b0;
    logic        flushed = 1'b0;
    logic [31:0] last_flush = '0;
    logic [31:0] interval = FLUSH_INTERVAL_RESET;
    out_item_t   pending_results [$];
    int          mismatch_count = 0;

    function void predict_item(in_item_t it);
      out_item_t exp_r;
      logic [5:0] slot;
      exp_r = '0;
      if (it.mode == MODE_PUSH) begin
        if (held < DEPTH_DEFAULT) begin
          slot = oldest + held[5:0];
          held = held + 7'd1;
        end else begin
          // full: overwrite the oldest pair and advance past it
          slot = oldest;
          oldest = oldest + 6'd1;
        end
        session_mem[slot] = it.session_in;
        weekly_mem[slot] = it.weekly_in;
        dirty = 1'b1;
        if (!flushed || (it.now_ms - last_flush) >= interval) begin
          exp_r.flush_due = 1'b1;
          dirty = 1'b0;
          flushed = 1'b1;
          last_flush = it.now_ms;
        end
      end else if (it.index < held) begin
        slot = oldest + it.index;
        exp_r.read_valid = 1'b1;
        exp_r.session_out = session_mem[slot];
        exp_r.weekly_out = weekly_mem[slot];
      end
      exp_r.sample_count = held;
      pending_results.push_back(exp_r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"%0t: result with no item pending: ",
                    "valid=%0d s=%02h w=%02h count=%0d flush=%0d"},
                   $realtime, got.read_valid, got.session_out, got.weekly_out,
                   got.sample_count, got.flush_due);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.read_valid !== exp_r.read_valid || got.session_out !== exp_r.session_out ||
          got.weekly_out !== exp_r.weekly_out || got.sample_count !== exp_r.sample_count ||
          got.flush_due !== exp_r.flush_due) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"%0t: mismatch: expected valid=%0d s=%02h w=%02h count=%0d flush=%0d, ",
                    "got valid=%0d s=%02h w=%02h count=%0d flush=%0d"},
                   $realtime, exp_r.read_valid, exp_r.session_out, exp_r.weekly_out,
                   exp_r.sample_count, exp_r.flush_due, got.read_valid, got.session_out,
                   got.weekly_out, got.sample_count, got.flush_due);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    item;
  logic        done;
  out_item_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  ring_tracker trk = new();
  logic [31:0] clock_ms = '0;

  history_ring_with_flush_gate_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("history_ring_with_flush_gate_unit test failed");
    $finish;
  end

  // Check results before noting the item taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) trk.check_result(result);
      if (start && !busy) trk.predict_item(item);
      if (cfg_valid && cfg_ready) trk.interval = cfg_data;
    end
  end

  function automatic in_item_t make_item(mode_t m, logic [7:0] s, logic [7:0] w,
                                         logic [5:0] idx, logic [31:0] now);
    in_item_t it;
    it.mode = m;
    it.session_in = s;
    it.weekly_in = w;
    it.index = idx;
    it.now_ms = now;
    return it;
  endfunction

  function automatic logic [31:0] next_now();
    logic [31:0] step;
    step = (trk.interval < 1000) ? trk.interval * 2 + 1 : trk.interval / 4;
    case ($urandom_range(9))
      0: clock_ms = $urandom();
      // land on the interval boundary or one short of it
      1: clock_ms = trk.last_flush + trk.interval - $urandom_range(1);
      2: clock_ms = trk.last_flush - 32'd1;
      default: clock_ms = clock_ms + $urandom_range(0, step);
    endcase
    return clock_ms;
  endfunction

  function automatic in_item_t random_item();
    logic [5:0] idx;
    if ($urandom_range(2) == 0 || trk.held == 0) idx = 6'($urandom_range(63));
    else idx = 6'($urandom_range(trk.held - 1));
    if ($urandom_range(9) < 6)
      return make_item(MODE_PUSH, 8'($urandom()), 8'($urandom()), 6'($urandom()),
                       next_now());
    return make_item(MODE_READ, 8'($urandom()), 8'($urandom()), idx, $urandom());
  endfunction

  // Hold start until the item is taken, then idle for a random gap at the odds idle_pct sets.
  task automatic send_item(in_item_t it, int idle_pct);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start, drain the block, then write the interval.
  task automatic write_interval(logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (trk.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] intervals [6];
    int          idle_pct [6];
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    intervals = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd50, 32'd250000};
    idle_pct = '{29, 29, 64, 64, 0, 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty reads, first push, exact and wrapped interval boundaries.
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd0, 32'd0), 0);
    send_item(make_item(MODE_READ, 8'hFF, 8'hFF, 6'd63, 32'hFFFF_FFFF), 0);
    send_item(make_item(MODE_PUSH, 8'h00, 8'hFF, 6'd0, 32'hFFFF_FFFF), 0);
    send_item(make_item(MODE_PUSH, 8'hFF, 8'h00, 6'd63, 32'd0), 0);
    send_item(make_item(MODE_PUSH, 8'hA5, 8'h5A, 6'd0, 32'd599_999), 0);
    send_item(make_item(MODE_PUSH, 8'h3C, 8'hC3, 6'd0, 32'd1_199_998), 0);
    send_item(make_item(MODE_PUSH, 8'h81, 8'h18, 6'd0, 32'd1_199_999), 0);
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd0, 32'd0), 0);
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd4, 32'd0), 0);
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd5, 32'd0), 0);
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd63, 32'd0), 0);
    send_item(make_item(MODE_PUSH, 8'hFF, 8'hFF, 6'd0, 32'd0), 0);
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd5, 32'd0), 29);
    send_item(make_item(MODE_PUSH, 8'h01, 8'h80, 6'd0, 32'd1), 29);
    send_item(make_item(MODE_READ, 8'h00, 8'h00, 6'd6, 32'd0), 0);

    for (int p = 0; p < 6; p++) begin
      write_interval(intervals[p]);
      for (int n = 0; n < 150; n++) send_item(random_item(), idle_pct[p]);
    end

    start <= 1'b0;
    while (trk.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (trk.mismatch_count == 0 && trk.pending_results.size() == 0)
      $display("history_ring_with_flush_gate_unit test passed");
    else
      $display("history_ring_with_flush_gate_unit test failed");
    $finish;
  end

endmodule

// ===== history_ring_with_flush_gate_unit.f =====
src/hrfg_pkg.sv
src/hrfg_ram.sv
src/hrfg_flush_gate.sv
src/hrfg_ring_ctrl.sv
src/history_ring_with_flush_gate_unit.sv
sim/testbench.sv
